/* design/mnca_pkg.sv */
// Shared constants, types and the neighbor tap table of the masked neighborhood averager.
package mnca_pkg;

    localparam int MAX_DIM     = 64;
    localparam int COORD_W     = $clog2(MAX_DIM);
    localparam int ADDR_W      = 2 * COORD_W;
    localparam int CELL_COUNT  = MAX_DIM * MAX_DIM;
    localparam int DIM_W       = 7;
    localparam int KEY_W       = 16;
    localparam int CH_W        = 8;
    localparam int RGB_W       = 3 * CH_W;
    localparam int CELL_W      = KEY_W + RGB_W;
    localparam int NUM_TAPS    = 9;
    localparam int TAP_W       = $clog2(NUM_TAPS);
    localparam int CENTER_TAP  = 0;
    localparam int SUM_W       = CH_W + TAP_W;
    localparam int DIV_STEPS   = CH_W;
    localparam int CNT_W       = TAP_W;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(MAX_DIM);

    // Controller to datapath commands.
    typedef struct packed {
        logic             capture;
        logic             mem_wr;
        logic             rd_en;
        logic [TAP_W-1:0] rd_k;
        logic             div_step;
        logic             load_out;
    } mnca_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_query;
        logic in_grid;
    } mnca_stat_t;

    // Tap 0 is the cell itself, taps 1..8 walk the neighbors row by row.
    function automatic logic [DIM_W-1:0] tap_dx(input logic [TAP_W-1:0] k);
        logic [DIM_W-1:0] off;
        case (k)
            TAP_W'(1), TAP_W'(4), TAP_W'(6): off = {DIM_W{1'b1}};
            TAP_W'(3), TAP_W'(5), TAP_W'(8): off = DIM_W'(1);
            default:                         off = '0;
        endcase
        return off;
    endfunction

    function automatic logic [DIM_W-1:0] tap_dy(input logic [TAP_W-1:0] k);
        logic [DIM_W-1:0] off;
        case (k)
            TAP_W'(1), TAP_W'(2), TAP_W'(3): off = {DIM_W{1'b1}};
            TAP_W'(6), TAP_W'(7), TAP_W'(8): off = DIM_W'(1);
            default:                         off = '0;
        endcase
        return off;
    endfunction

endpackage

/* design/mnca_ctrl.sv */
// Sequencer for write, neighbor read, divide and result hand-off.
module mnca_ctrl
    import mnca_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_ready,
    output logic       out_valid,
    input  mnca_stat_t stat,
    output mnca_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_DRAIN,
        S_DIVIDE,
        S_DONE
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = (state_reg == S_IDLE) && in_valid;
        cmd.mem_wr   = (state_reg == S_EXEC) && !stat.is_query && stat.in_grid;
        cmd.rd_en    = (state_reg == S_READ);
        cmd.rd_k     = TAP_W'(cnt_reg);
        cmd.div_step = (state_reg == S_DIVIDE);
        cmd.load_out = (state_reg == S_DONE) && slot_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    cnt_reg <= '0;
                    if (!stat.is_query)
                        state_reg <= S_IDLE;
                    else if (stat.in_grid)
                        state_reg <= S_READ;
                    else
                        state_reg <= S_DONE;
                end
                S_READ:
                begin
                    if (cnt_reg == CNT_W'(NUM_TAPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DRAIN;
                    end
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                S_DRAIN:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIVIDE;
                end
                S_DIVIDE:
                begin
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                S_DONE:
                begin
                    if (slot_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_wr_never_on_query: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> !stat.is_query)
        else $error("memory write issued for a query");

    a_read_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (cnt_reg < CNT_W'(NUM_TAPS)))
        else $error("tap counter ran past the last neighbor");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("result load did not raise the output valid");

endmodule

/* design/mnca_dp.sv */
// Grid memory, neighbor accumulation, shift-subtract divide and result register.
module mnca_dp
    import mnca_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [DIM_W-1:0]       cfg_data,
    input  logic [IN_TDATA_W-1:0]  in_data,
    input  logic                   in_user,
    input  mnca_cmd_t              cmd,
    output mnca_stat_t             stat,
    output logic [OUT_TDATA_W-1:0] out_data,
    output logic                   out_user
);

    logic [DIM_W-1:0]   grid_width_reg;
    logic [DIM_W-1:0]   grid_height_reg;
    logic [DIM_W-1:0]   w_lim;
    logic [DIM_W-1:0]   h_lim;

    logic               is_query_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [KEY_W-1:0]   wr_key_reg;
    logic [RGB_W-1:0]   wr_rgb_reg;

    logic [CELL_W-1:0]  mem [CELL_COUNT];
    logic [CELL_W-1:0]  mem_q_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [DIM_W-1:0]   nx;
    logic [DIM_W-1:0]   ny;
    logic               tap_inb;

    logic               rd_valid_reg;
    logic [TAP_W-1:0]   rd_k_reg;
    logic               rd_inb_reg;

    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   key_next;
    logic [SUM_W-1:0]   sum_reg  [3];
    logic [SUM_W-1:0]   sum_next [3];
    logic [TAP_W-1:0]   n_reg;
    logic [TAP_W-1:0]   n_next;

    logic [KEY_W-1:0]   q_key;
    logic               take;

    logic [CH_W-1:0]    avg_reg [3];
    logic [TAP_W-1:0]   count_reg;
    logic               oor_reg;

    // Grid size above the maximum saturates.
    assign w_lim = (grid_width_reg  > DIM_LIMIT) ? DIM_LIMIT : grid_width_reg;
    assign h_lim = (grid_height_reg > DIM_LIMIT) ? DIM_LIMIT : grid_height_reg;

    assign stat.is_query = is_query_reg;
    assign stat.in_grid  = ({1'b0, x_reg} < w_lim) && ({1'b0, y_reg} < h_lim);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= DIM_LIMIT;
            grid_height_reg <= DIM_LIMIT;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_GRID_WIDTH)
                grid_width_reg <= cfg_data;
            else if (cfg_index == REG_GRID_HEIGHT)
                grid_height_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            is_query_reg <= in_user;
            x_reg        <= in_data[0 +: COORD_W];
            y_reg        <= in_data[COORD_W +: COORD_W];
            wr_key_reg   <= in_data[2*COORD_W +: KEY_W];
            // Store as {red, green, blue}.
            wr_rgb_reg   <= {in_data[2*COORD_W+KEY_W +: CH_W],
                             in_data[2*COORD_W+KEY_W+CH_W +: CH_W],
                             in_data[2*COORD_W+KEY_W+2*CH_W +: CH_W]};
        end
    end

    // Neighbor position; a step below zero wraps high and fails the bound check.
    assign nx      = {1'b0, x_reg} + tap_dx(cmd.rd_k);
    assign ny      = {1'b0, y_reg} + tap_dy(cmd.rd_k);
    assign tap_inb = (nx < w_lim) && (ny < h_lim);
    assign rd_addr = {ny[COORD_W-1:0], nx[COORD_W-1:0]};
    assign wr_addr = {y_reg, x_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
            mem[wr_addr] <= {wr_key_reg, wr_rgb_reg};
        if (cmd.rd_en)
            mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else
            rd_valid_reg <= cmd.rd_en;
    end

    always_ff @(posedge clk)
    begin
        rd_k_reg   <= cmd.rd_k;
        rd_inb_reg <= tap_inb;
    end

    assign q_key = mem_q_reg[RGB_W +: KEY_W];
    assign take  = (rd_k_reg == TAP_W'(CENTER_TAP)) || (rd_inb_reg && (q_key == key_reg));

    always_comb
    begin
        logic [TAP_W:0] trial;
        logic           qbit;
        trial    = '0;
        qbit     = 1'b0;
        key_next = key_reg;
        n_next   = n_reg;
        for (int c = 0; c < 3; c++)
            sum_next[c] = sum_reg[c];

        if (cmd.capture)
        begin
            n_next = '0;
            for (int c = 0; c < 3; c++)
                sum_next[c] = '0;
        end
        else if (rd_valid_reg)
        begin
            // The center tap arrives first and sets the key for the rest.
            if (rd_k_reg == TAP_W'(CENTER_TAP))
                key_next = q_key;
            if (take)
            begin
                n_next = n_reg + TAP_W'(1);
                for (int c = 0; c < 3; c++)
                    sum_next[c] = sum_reg[c]
                                + SUM_W'(mem_q_reg[(2 - c)*CH_W +: CH_W]);
            end
        end
        else if (cmd.div_step)
        begin
            // Restoring divide in place: high bits hold the remainder, low bits
            // shift the dividend out and the quotient in. Sum < 256*n keeps the
            // starting remainder below n.
            for (int c = 0; c < 3; c++)
            begin
                trial = {sum_reg[c][SUM_W-1 -: TAP_W], sum_reg[c][CH_W-1]};
                qbit  = (trial >= {1'b0, n_reg});
                if (qbit)
                    trial = trial - {1'b0, n_reg};
                sum_next[c] = {trial[TAP_W-1:0], sum_reg[c][CH_W-2:0], qbit};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        n_reg   <= n_next;
        for (int c = 0; c < 3; c++)
            sum_reg[c] <= sum_next[c];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            for (int c = 0; c < 3; c++)
                avg_reg[c] <= stat.in_grid ? sum_reg[c][CH_W-1:0] : '0;
            count_reg <= stat.in_grid ? n_reg : '0;
            oor_reg   <= !stat.in_grid;
        end
    end

    assign out_data = {{(OUT_TDATA_W - 3*CH_W - TAP_W){1'b0}}, count_reg,
                       avg_reg[2], avg_reg[1], avg_reg[0]};
    assign out_user = oor_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && stat.in_grid) |-> (n_reg != '0 && n_reg <= TAP_W'(NUM_TAPS)))
        else $error("sample count outside one to nine at result load");

    a_oor_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && !stat.in_grid) |=> (oor_reg && count_reg == '0))
        else $error("out-of-range result carries a nonzero count");

endmodule

/* design/masked_neighbourhood_colour_average.sv */
// Top level of the masked 3x3 neighborhood color averager.
//
// Holds a 64x64 grid of cells, each a 16-bit height key and an RGB color, in
// one single-port memory (4096 x 40 bits, read data registered). An input
// transaction with tuser 0 writes a cell (ignored outside the configured grid)
// and yields nothing; with tuser 1 it queries a cell and yields one output
// transaction: the cell's color averaged with each in-bounds neighbor whose key
// equals the cell's, each channel truncated, plus the sample count (1..9). A
// query outside the grid yields zeros with tuser set. An input transaction is
// taken only in the idle state. A write then returns to idle; a query outside
// the grid goes straight to the result; a query in the grid first makes the
// nine memory reads through the one port, waits out the last read data, and
// then runs the 8-step shift-subtract divide on all three channels at once.
// A finished result sits in the output register while the next transaction is
// accepted; a query result waits for that register to drain. Write grid_width
// (index 0) and grid_height (index 1) only while the block is idle; sizes
// above 64 saturate to 64. Memory contents are undefined until written, and
// querying a cell or matching neighbor never written gives undefined values.
module masked_neighbourhood_colour_average
    import mnca_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [DIM_W-1:0]       cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // cell_x[5:0], cell_y[11:6], height_key[27:12], in_red[35:28],
    // in_green[43:36], in_blue[51:44], zero pad [55:52]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // command: 0 write, 1 query
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // avg_red[7:0], avg_green[15:8], avg_blue[23:16], sample_count[27:24],
    // zero pad [31:28]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // out_of_range
    output logic                   m_axis_tuser
);

    mnca_cmd_t  cmd;
    mnca_stat_t stat;

    // Sequence each transaction; hold the result valid until taken.
    mnca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Store cells, gather matching neighbors, divide and register the result.
    mnca_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

/* verif/tb.sv */
// Self-checking testbench for the masked 3x3 neighborhood color averager.
module tb;
    import mnca_pkg::*;

    // Cycles with no transaction on either side before the run is declared hung.
    // The slowest query runs its reads and divide and then waits out sink stalls,
    // so this is far beyond any correct run.
    localparam int STALL_LIMIT   = 2000;
    // Idle time after the last result before a register write (a write yields
    // no result, so it may still be in flight).
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 30;

    // Register indexes past the end of the register list; the block ignores them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cell_cmd_e;

    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CNT_W-1:0] sample_count;
        logic             out_of_range;
    } cell_average_t;

    // Shadow of the grid and the grid size, plus the queue of averages still owed.
    class color_average_board;
        logic [KEY_W-1:0] key_mem [CELL_COUNT];
        logic [RGB_W-1:0] rgb_mem [CELL_COUNT];
        bit               written [CELL_COUNT];
        logic [DIM_W-1:0] width_reg;
        logic [DIM_W-1:0] height_reg;
        cell_average_t    expected_averages [$];
        int               mismatches;
        int               averages_checked;
        int               out_of_range_checked;
        int               writes_stored;
        int               count_seen [NUM_TAPS + 1];

        function new();
            width_reg  = DIM_LIMIT;
            height_reg = DIM_LIMIT;
        endfunction

        // Sizes above the grid memory saturate.
        function int span_x();
            return (width_reg > DIM_LIMIT) ? MAX_DIM : int'(width_reg);
        endfunction

        function int span_y();
            return (height_reg > DIM_LIMIT) ? MAX_DIM : int'(height_reg);
        endfunction

        function bit covers(int x, int y);
            return x >= 0 && y >= 0 && x < span_x() && y < span_y();
        endfunction

        function int pending();
            return expected_averages.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [DIM_W-1:0] value);
            if (index == REG_GRID_WIDTH)
                width_reg = value;
            else if (index == REG_GRID_HEIGHT)
                height_reg = value;
        endfunction

        // Own color plus every in-grid neighbor whose key matches, each channel
        // divided by the count with truncation.
        function cell_average_t average_neighborhood(int x, int y);
            cell_average_t    res;
            logic [KEY_W-1:0] own_key;
            logic [RGB_W-1:0] rgb;
            int               sum_r;
            int               sum_g;
            int               sum_b;
            int               n;
            int               addr;
            int               dx;
            int               dy;
            res   = '0;
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            n     = 0;
            if (!covers(x, y))
            begin
                res.out_of_range = 1'b1;
                return res;
            end
            own_key = key_mem[y * MAX_DIM + x];
            for (dy = -1; dy <= 1; dy++)
            begin
                for (dx = -1; dx <= 1; dx++)
                begin
                    if (!covers(x + dx, y + dy))
                        continue;
                    addr = (y + dy) * MAX_DIM + x + dx;
                    if ((dx != 0 || dy != 0) && key_mem[addr] != own_key)
                        continue;
                    rgb    = rgb_mem[addr];
                    sum_r += rgb[23:16];
                    sum_g += rgb[15:8];
                    sum_b += rgb[7:0];
                    n++;
                end
            end
            res.red          = CH_W'(sum_r / n);
            res.green        = CH_W'(sum_g / n);
            res.blue         = CH_W'(sum_b / n);
            res.sample_count = CNT_W'(n);
            return res;
        endfunction

        function void note_input(cell_cmd_e cmd, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                 logic [KEY_W-1:0] key, logic [CH_W-1:0] red,
                                 logic [CH_W-1:0] green, logic [CH_W-1:0] blue);
            cell_average_t want;
            if (cmd == CMD_WRITE)
            begin
                if (covers(x, y))
                begin
                    key_mem[y * MAX_DIM + x] = key;
                    rgb_mem[y * MAX_DIM + x] = {red, green, blue};
                    written[y * MAX_DIM + x] = 1'b1;
                    writes_stored++;
                end
            end
            else
            begin
                want = average_neighborhood(x, y);
                count_seen[want.sample_count]++;
                expected_averages.push_back(want);
            end
        endfunction

        function void flag_field(string name, logic [15:0] want_v, logic [15:0] got_v);
            if (got_v !== want_v)
            begin
                mismatches++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic flag);
            cell_average_t want;
            if (expected_averages.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with none awaited, expected nothing actual tdata %h tuser %b",
                         $time, data, flag);
                return;
            end
            want = expected_averages.pop_front();
            if (want.out_of_range)
                out_of_range_checked++;
            else
                averages_checked++;
            flag_field("avg_red", want.red, data[7:0]);
            flag_field("avg_green", want.green, data[15:8]);
            flag_field("avg_blue", want.blue, data[23:16]);
            flag_field("sample_count", want.sample_count, data[27:24]);
            flag_field("out_of_range", want.out_of_range, flag);
        endfunction
    endclass

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index      = '0;
    logic [DIM_W-1:0]       cfg_data       = '0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    // cell_x, cell_y, height_key, in_red, in_green, in_blue, zero pad (low bit up)
    logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
    // command
    logic                   s_axis_tuser   = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    // avg_red, avg_green, avg_blue, sample_count, zero pad (low bit up)
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // out_of_range
    logic                   m_axis_tuser;

    color_average_board sb;
    bit                 gaps_on        = 1'b1;
    bit                 sink_stalls_on = 1'b1;
    int                 items_sent     = 0;
    int                 settings_used  = 0;
    int                 quiet_cycles   = 0;
    logic [KEY_W-1:0]   key_pool [3];

    masked_neighbourhood_colour_average u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: check every accepted result, then pick next cycle's tready.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= !sink_stalls_on || ($urandom_range(0, 99) >= 15);
    end

    // Watchdog: end the run when neither side has moved a transaction for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, sb.pending());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [CH_W-1:0] pick_ch();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        return CH_W'($urandom_range(0, 255));
    endfunction

    // Mostly keys from a small per-phase pool so that neighbors match often.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return key_pool[$urandom_range(0, 2)];
        return KEY_W'($urandom);
    endfunction

    // Bias coordinates toward the low corner and the far edge of the grid; a
    // share spans the whole field, which lands outside small grids.
    function automatic int pick_coord(int span);
        int r;
        r = $urandom_range(0, 99);
        if (span == 0 || r < 12)
            return $urandom_range(0, MAX_DIM - 1);
        if (r < 28)
            return $urandom_range((span > 3) ? span - 3 : 0, span - 1);
        return $urandom_range(0, ((span < 10) ? span : 10) - 1);
    endfunction

    // Present one input transaction and hold it until it is taken. A gap drops
    // tvalid first; back-to-back items keep tvalid high without a dip.
    task automatic send_cell(input cell_cmd_e cmd, input int x, input int y,
                             input logic [KEY_W-1:0] key, input logic [CH_W-1:0] red,
                             input logic [CH_W-1:0] green, input logic [CH_W-1:0] blue);
        while (gaps_on && $urandom_range(0, 99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= IN_TDATA_W'({blue, green, red, key, COORD_W'(y), COORD_W'(x)});
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_input(cmd, COORD_W'(x), COORD_W'(y), key, red, green, blue);
        items_sent++;
    endtask

    task automatic random_write(input int x, input int y);
        send_cell(CMD_WRITE, x, y, pick_key(), pick_ch(), pick_ch(), pick_ch());
    endtask

    // A query may only touch cells that hold data, so first write the cell and
    // any in-grid neighbor still empty, favoring the cell's own key.
    task automatic query_cell(input int x, input int y);
        logic [KEY_W-1:0] own_key;
        int               dx;
        int               dy;
        if (sb.covers(x, y))
        begin
            if (!sb.written[y * MAX_DIM + x])
                random_write(x, y);
            own_key = sb.key_mem[y * MAX_DIM + x];
            for (dy = -1; dy <= 1; dy++)
            begin
                for (dx = -1; dx <= 1; dx++)
                begin
                    if (sb.covers(x + dx, y + dy) && !sb.written[(y + dy) * MAX_DIM + x + dx])
                        send_cell(CMD_WRITE, x + dx, y + dy,
                                  ($urandom_range(0, 99) < 60) ? own_key : pick_key(),
                                  pick_ch(), pick_ch(), pick_ch());
                end
            end
        end
        // The write fields ride along unused; random content toggles their bits.
        send_cell(CMD_QUERY, x, y, KEY_W'($urandom), pick_ch(), pick_ch(), pick_ch());
    endtask

    // Drop tvalid, wait out every owed result, then let trailing writes finish.
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both grid sizes on back-to-back cycles; optionally poke the unused
    // indexes, which must change nothing.
    task automatic program_grid(input logic [DIM_W-1:0] grid_w, input logic [DIM_W-1:0] grid_h,
                                input bit poke_unused);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GRID_WIDTH;
        cfg_data  <= grid_w;
        @(posedge clk);
        sb.write_reg(REG_GRID_WIDTH, grid_w);
        cfg_index <= REG_GRID_HEIGHT;
        cfg_data  <= grid_h;
        @(posedge clk);
        sb.write_reg(REG_GRID_HEIGHT, grid_h);
        if (poke_unused)
        begin
            cfg_index <= REG_SPARE_A;
            cfg_data  <= DIM_W'($urandom);
            @(posedge clk);
            cfg_index <= REG_SPARE_B;
            cfg_data  <= DIM_W'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Hand-picked items at the reset grid size: all-ones and all-zero keys and
    // colors, corner queries and an interior query with one masked neighbor.
    task automatic run_directed();
        int dx;
        int dy;
        send_cell(CMD_WRITE, 0, 0, '1, '1, '1, '1);
        send_cell(CMD_WRITE, 1, 0, '1, '1, '0, '1);
        send_cell(CMD_WRITE, 0, 1, '1, '0, '1, '1);
        send_cell(CMD_WRITE, 1, 1, '0, '0, '0, '0);
        query_cell(0, 0);
        for (dy = MAX_DIM - 3; dy < MAX_DIM; dy++)
        begin
            for (dx = MAX_DIM - 3; dx < MAX_DIM; dx++)
                send_cell(CMD_WRITE, dx, dy,
                          (dx == MAX_DIM - 3 && dy == MAX_DIM - 3) ? 16'h0000 : 16'h5A5A,
                          pick_ch(), pick_ch(), pick_ch());
        end
        query_cell(MAX_DIM - 2, MAX_DIM - 2);
        query_cell(MAX_DIM - 1, MAX_DIM - 1);
        query_cell(MAX_DIM - 3, MAX_DIM - 3);
    endtask

    // One grid setting: drain, reprogram, then random writes, noise writes and
    // well-formed queries. Optionally hold the sender halfway until all results
    // are back, and optionally run with no idling on either side.
    task automatic run_phase(input logic [DIM_W-1:0] grid_w, input logic [DIM_W-1:0] grid_h,
                             input int item_count, input bit poke_unused, input bit calm,
                             input bit pause_midway);
        int  start;
        int  r;
        bit  paused;
        wait_until_drained();
        program_grid(grid_w, grid_h, poke_unused);
        gaps_on        = !calm;
        sink_stalls_on = !calm;
        key_pool[0]    = $urandom_range(0, 1) ? '1 : '0;
        key_pool[1]    = KEY_W'($urandom);
        key_pool[2]    = KEY_W'($urandom);
        start          = items_sent;
        paused         = 1'b0;
        while (items_sent - start < item_count)
        begin
            if (pause_midway && !paused && items_sent - start >= item_count / 2)
            begin
                wait_until_drained();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 30)
                random_write(pick_coord(sb.span_x()), pick_coord(sb.span_y()));
            else if (r < 38)
                random_write($urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1));
            else
                query_cell(pick_coord(sb.span_x()), pick_coord(sb.span_y()));
        end
    endtask

    initial
    begin
        int counts_hit;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 16'h5A5A;
        run_directed();

        // Small grids, a single cell, an empty grid, saturating sizes, a long
        // stretch with no idling, thin strips, and a mid-phase drain.
        run_phase(7'd4, 7'd3, 200, 1'b0, 1'b0, 1'b0);
        run_phase(7'd1, 7'd1, 60, 1'b0, 1'b0, 1'b0);
        run_phase(7'd0, 7'd0, 50, 1'b0, 1'b0, 1'b0);
        run_phase(7'd127, 7'd127, 250, 1'b0, 1'b0, 1'b0);
        run_phase(7'd10, 7'd64, 250, 1'b0, 1'b1, 1'b0);
        run_phase(7'd64, 7'd1, 150, 1'b0, 1'b0, 1'b0);
        run_phase(7'd7, 7'd9, 250, 1'b1, 1'b0, 1'b0);
        run_phase(7'd65, 7'd2, 120, 1'b0, 1'b0, 1'b0);
        run_phase(7'd12, 7'd12, 560, 1'b0, 1'b0, 1'b1);

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        counts_hit = 0;
        foreach (sb.count_seen[i])
            if (sb.count_seen[i] != 0)
                counts_hit++;
        $display("summary: %0d input transactions over %0d grid settings, %0d cell writes stored",
                 items_sent, settings_used, sb.writes_stored);
        $display("summary: %0d averages and %0d out-of-range results checked, %0d of 10 counts hit",
                 sb.averages_checked, sb.out_of_range_checked, counts_hit);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* masked_neighbourhood_colour_average.f */
design/mnca_pkg.sv
design/mnca_ctrl.sv
design/mnca_dp.sv
design/masked_neighbourhood_colour_average.sv
verif/tb.sv
